// ----- sv/mmio_range_match_unit_macros.svh -----
// ----------------------------------------------------------------------------
// mmio_range_match_unit_macros.svh
// Assertion macros for the range match unit checker.
// ----------------------------------------------------------------------------
`ifndef MMIO_RANGE_MATCH_UNIT_MACROS_SVH
`define MMIO_RANGE_MATCH_UNIT_MACROS_SVH

// Plain property check on aclk, off while aresetn is low
`define MRMU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// A result that is stalled keeps the given field unchanged
`define MRMU_ASSERT_HOLD(lbl, sig) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (m_valid && !m_ready) |=> $stable(sig)) else $error("stalled result changed");

`endif

// ----- sv/mrmu_pkg.sv -----
// ----------------------------------------------------------------------------
// mrmu_pkg
// Constants, codes and types of the MMIO range match unit.
// ----------------------------------------------------------------------------
package mrmu_pkg;

    // Table size and field widths
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OP_W    = 2;
    localparam int ADDR_W  = 64;
    localparam int RSIZE_W = 32;
    localparam int ASIZE_W = 7;
    localparam int MODE_W  = 2;
    localparam int COMP_W  = 8;
    localparam int STAT_W  = 3;
    localparam int OFF_W   = 32;

    // Opcodes
    localparam logic [OP_W-1:0] OP_REGISTER = 2'd0;
    localparam logic [OP_W-1:0] OP_READ     = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE    = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STAT_W-1:0] STAT_OVERLAP = 3'd1;
    localparam logic [STAT_W-1:0] STAT_FULL    = 3'd2;
    localparam logic [STAT_W-1:0] STAT_ZERO    = 3'd3;
    localparam logic [STAT_W-1:0] STAT_NORANGE = 3'd4;
    localparam logic [STAT_W-1:0] STAT_MODE    = 3'd5;

    // Permission bits of a range
    localparam int MODE_READ_BIT  = 0;
    localparam int MODE_WRITE_BIT = 1;

    // One stored range
    typedef struct packed {
        logic [ADDR_W-1:0]  base;
        logic [RSIZE_W-1:0] length;
        logic [MODE_W-1:0]  mode;
        logic [COMP_W-1:0]  owner;
    } entry_t;

    // Compare unit answer for one entry
    typedef struct packed {
        logic             overlap;
        logic             match;
        logic             at_base;
        logic [OFF_W-1:0] offset;
    } cmp_res_t;

endpackage

// ----- sv/mrmu_ram.sv -----
// ----------------------------------------------------------------------------
// mrmu_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mrmu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- sv/mrmu_cmp.sv -----
// ----------------------------------------------------------------------------
// mrmu_cmp
// Shared compare unit: checks one stored range against the current item.
// ----------------------------------------------------------------------------
module mrmu_cmp (
    input  logic [mrmu_pkg::ADDR_W-1:0]  address,
    input  logic [mrmu_pkg::RSIZE_W-1:0] region_size,
    input  logic [mrmu_pkg::ASIZE_W-1:0] access_size,
    input  mrmu_pkg::entry_t             entry,
    output mrmu_pkg::cmp_res_t           res
);
    import mrmu_pkg::*;

    logic [ADDR_W:0]    diff;
    logic               addr_ge;
    logic [ADDR_W-1:0]  dlo;
    logic [ADDR_W-1:0]  dneg;
    logic               len_fits;
    logic [RSIZE_W-1:0] room;

    // One wide subtract serves both overlap and containment
    assign diff    = {1'b0, address} - {1'b0, entry.base};
    assign addr_ge = !diff[ADDR_W];
    assign dlo     = diff[ADDR_W-1:0];
    assign dneg    = '0 - dlo;

    // Overlap of [address, +region_size) with [base, +length)
    assign res.overlap = addr_ge ? (dlo  < {{(ADDR_W-RSIZE_W){1'b0}}, entry.length})
                                 : (dneg < {{(ADDR_W-RSIZE_W){1'b0}}, region_size});

    // Access lies wholly inside the range
    assign len_fits  = entry.length >= {{(RSIZE_W-ASIZE_W){1'b0}}, access_size};
    assign room      = entry.length - {{(RSIZE_W-ASIZE_W){1'b0}}, access_size};
    assign res.match = addr_ge && len_fits &&
                       (dlo <= {{(ADDR_W-RSIZE_W){1'b0}}, room});

    // Access starts at the range base: wins over an adjacent range
    assign res.at_base = addr_ge && (dlo == '0);
    assign res.offset  = dlo[OFF_W-1:0];

endmodule

// ----- sv/mmio_range_match_unit.sv -----
// ----------------------------------------------------------------------------
// mmio_range_match_unit
// Lookups and registrations scan every table entry, one per cycle, through
// the shared compare unit, then pass S_DRAIN and S_FINISH, which registers
// the result once the output is free. A zero-size registration or an
// unknown opcode skips the scan. Each new item waits for the last result.
// Reset clears all range valid bits (empty table); no clearing pass is needed.
// ----------------------------------------------------------------------------
module mmio_range_match_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mrmu_pkg::OP_W-1:0]     s_opcode,
    input  logic [mrmu_pkg::ADDR_W-1:0]   s_address,
    input  logic [mrmu_pkg::RSIZE_W-1:0]  s_region_size,
    input  logic [mrmu_pkg::ASIZE_W-1:0]  s_access_size,
    input  logic [mrmu_pkg::MODE_W-1:0]   s_access_mode,
    input  logic [mrmu_pkg::COMP_W-1:0]   s_component_id,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mrmu_pkg::STAT_W-1:0]   m_status,
    output logic [mrmu_pkg::COMP_W-1:0]   m_hit_component,
    output logic [mrmu_pkg::OFF_W-1:0]    m_offset
);
    import mrmu_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_FINISH} state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    state_t              state_reg, state_next;
    logic [ENTRIES-1:0]  range_valid_reg, range_valid_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                pend_vld_reg, pend_vld_next;
    logic [IDX_W-1:0]    pend_idx_reg, pend_idx_next;
    logic                ovl_reg, ovl_next;
    logic                free_found_reg, free_found_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic                found_reg, found_next;
    logic [COMP_W-1:0]   best_owner_reg, best_owner_next;
    logic [MODE_W-1:0]   best_mode_reg, best_mode_next;
    logic [OFF_W-1:0]    best_off_reg, best_off_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [RSIZE_W-1:0]  rsize_reg, rsize_next;
    logic [ASIZE_W-1:0]  asize_reg, asize_next;
    logic [MODE_W-1:0]   amode_reg, amode_next;
    logic [COMP_W-1:0]   comp_reg, comp_next;
    logic                m_valid_reg, m_valid_next;
    logic [STAT_W-1:0]   m_status_reg, m_status_next;
    logic [COMP_W-1:0]   m_hit_reg, m_hit_next;
    logic [OFF_W-1:0]    m_off_reg, m_off_next;

    logic                ram_we;
    entry_t              ram_wdata;
    entry_t              ram_rdata;
    cmp_res_t            cmp;
    logic                perm_ok;

    // Range table storage
    mrmu_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (free_idx_reg),
        .wr_data (ram_wdata),
        .rd_addr (idx_reg),
        .rd_data (ram_rdata)
    );

    assign ram_wdata = '{base: addr_reg, length: rsize_reg, mode: amode_reg, owner: comp_reg};

    // Shared compare unit
    mrmu_cmp u_cmp (
        .address     (addr_reg),
        .region_size (rsize_reg),
        .access_size (asize_reg),
        .entry       (ram_rdata),
        .res         (cmp)
    );

    assign perm_ok = (op_reg == OP_READ) ? best_mode_reg[MODE_READ_BIT]
                                         : best_mode_reg[MODE_WRITE_BIT];

    // Sequencer next state
    always_comb begin
        state_next       = state_reg;
        range_valid_next = range_valid_reg;
        idx_next         = idx_reg;
        pend_vld_next    = pend_vld_reg;
        pend_idx_next    = pend_idx_reg;
        ovl_next         = ovl_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        found_next       = found_reg;
        best_owner_next  = best_owner_reg;
        best_mode_next   = best_mode_reg;
        best_off_next    = best_off_reg;
        op_next          = op_reg;
        addr_next        = addr_reg;
        rsize_next       = rsize_reg;
        asize_next       = asize_reg;
        amode_next       = amode_reg;
        comp_next        = comp_reg;
        m_valid_next     = m_valid_reg;
        m_status_next    = m_status_reg;
        m_hit_next       = m_hit_reg;
        m_off_next       = m_off_reg;
        ram_we           = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // Fold in the entry read out last cycle
        if (pend_vld_reg) begin
            if (range_valid_reg[pend_idx_reg]) begin
                if (cmp.overlap) begin
                    ovl_next = 1'b1;
                end
                if (cmp.match && (!found_reg || cmp.at_base)) begin
                    found_next      = 1'b1;
                    best_owner_next = ram_rdata.owner;
                    best_mode_next  = ram_rdata.mode;
                    best_off_next   = cmp.offset;
                end
            end else if (!free_found_reg) begin
                free_found_next = 1'b1;
                free_idx_next   = pend_idx_reg;
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next         = s_opcode;
                    addr_next       = s_address;
                    rsize_next      = s_region_size;
                    asize_next      = s_access_size;
                    amode_next      = s_access_mode;
                    comp_next       = s_component_id;
                    idx_next        = '0;
                    pend_vld_next   = 1'b0;
                    ovl_next        = 1'b0;
                    free_found_next = 1'b0;
                    found_next      = 1'b0;
                    if ((s_opcode == OP_REGISTER && s_region_size == '0) ||
                        (s_opcode != OP_REGISTER && s_opcode != OP_READ &&
                         s_opcode != OP_WRITE)) begin
                        state_next = S_FINISH;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                pend_vld_next = 1'b1;
                pend_idx_next = idx_reg;
                if (idx_reg == LAST_IDX) begin
                    state_next = S_DRAIN;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DRAIN: begin
                pend_vld_next = 1'b0;
                state_next    = S_FINISH;
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_hit_next    = '0;
                    m_off_next    = '0;
                    state_next    = S_IDLE;
                    if (op_reg == OP_REGISTER) begin
                        if (rsize_reg == '0) begin
                            m_status_next = STAT_ZERO;
                        end else if (ovl_reg) begin
                            m_status_next = STAT_OVERLAP;
                        end else if (!free_found_reg) begin
                            m_status_next = STAT_FULL;
                        end else begin
                            m_status_next                  = STAT_OK;
                            ram_we                         = 1'b1;
                            range_valid_next[free_idx_reg] = 1'b1;
                        end
                    end else if (op_reg == OP_READ || op_reg == OP_WRITE) begin
                        if (!found_reg) begin
                            m_status_next = STAT_NORANGE;
                        end else if (!perm_ok) begin
                            m_status_next = STAT_MODE;
                        end else begin
                            m_status_next = STAT_OK;
                            m_hit_next    = best_owner_reg;
                            m_off_next    = best_off_reg;
                        end
                    end else begin
                        m_status_next = STAT_NORANGE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            range_valid_reg <= '0;
            pend_vld_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            range_valid_reg <= range_valid_next;
            pend_vld_reg    <= pend_vld_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Scan bookkeeping and payload
    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        pend_idx_reg   <= pend_idx_next;
        ovl_reg        <= ovl_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        found_reg      <= found_next;
        best_owner_reg <= best_owner_next;
        best_mode_reg  <= best_mode_next;
        best_off_reg   <= best_off_next;
        op_reg         <= op_next;
        addr_reg       <= addr_next;
        rsize_reg      <= rsize_next;
        asize_reg      <= asize_next;
        amode_reg      <= amode_next;
        comp_reg       <= comp_next;
        m_status_reg   <= m_status_next;
        m_hit_reg      <= m_hit_next;
        m_off_reg      <= m_off_next;
    end

    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_hit_component = m_hit_reg;
    assign m_offset        = m_off_reg;

endmodule

// ----- sv/mrmu_checker.sv -----
// ----------------------------------------------------------------------------
// mrmu_checker
// Port-level checks of the MMIO range match unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "mmio_range_match_unit_macros.svh"

module mrmu_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [mrmu_pkg::STAT_W-1:0]   m_status,
    input logic [mrmu_pkg::COMP_W-1:0]   m_hit_component,
    input logic [mrmu_pkg::OFF_W-1:0]    m_offset
);
    import mrmu_pkg::*;

    // One item at a time: busy right after an accept
    `MRMU_ASSERT(a_busy_after_accept, (s_valid && s_ready) |=> !s_ready, "ready after accept")

    // Status codes stay within the defined set
    `MRMU_ASSERT(a_status_range, m_valid |-> (m_status <= STAT_MODE), "bad status code")

    // Failed results carry no owner and no offset
    `MRMU_ASSERT(a_fail_clean, (m_valid && m_status != STAT_OK) |-> (m_hit_component == '0 && m_offset == '0), "payload on failed item")

    // Stalled results hold their status and offset
    `MRMU_ASSERT_HOLD(a_hold_status, m_status)
    `MRMU_ASSERT_HOLD(a_hold_offset, m_offset)

endmodule

bind mmio_range_match_unit mrmu_checker u_mrmu_checker (.*);

// ----- tb/mmio_range_match_unit_tb.sv -----
// ----------------------------------------------------------------------------
// mmio_range_match_unit_tb
// Self-checking bench for the MMIO range match unit. A table of directed
// items covers empty-table lookups, the zero, overlap and OK register
// statuses, adjacent ranges, zero-size lookups, permission failures and the
// top of the address space. Random items then fill the table and aim lookups
// at stored ranges, their edges and their gaps. Every result is checked against
// its row's own answer or a local model of the range table; both channels idle at random.
// ----------------------------------------------------------------------------
module mmio_range_match_unit_tb;
    import mrmu_pkg::*;

    // Opcode with no operation behind it
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS   = 1350;
    localparam int DIRECTED_ITEMS = 23;
    localparam int STALL_LIMIT    = 2000;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [ADDR_W-1:0]  addr;
        logic [RSIZE_W-1:0] rsize;
        logic [ASIZE_W-1:0] asize;
        logic [MODE_W-1:0]  mode;
        logic [COMP_W-1:0]  comp;
    } access_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [COMP_W-1:0] hit;
        logic [OFF_W-1:0]  off;
    } answer_t;

    // One row of the directed table; typed rows carry their own answer
    typedef struct packed {
        access_t item;
        logic    typed;
        answer_t ans;
    } dir_row_t;

    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_opcode       = '0;
    logic [ADDR_W-1:0]   s_address      = '0;
    logic [RSIZE_W-1:0]  s_region_size  = '0;
    logic [ASIZE_W-1:0]  s_access_size  = '0;
    logic [MODE_W-1:0]   s_access_mode  = '0;
    logic [COMP_W-1:0]   s_component_id = '0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic [STAT_W-1:0]   m_status;
    logic [COMP_W-1:0]   m_hit_component;
    logic [OFF_W-1:0]    m_offset;

    // Local copy of the range table
    bit                 map_used  [ENTRIES];
    logic [ADDR_W-1:0]  map_base  [ENTRIES];
    logic [RSIZE_W-1:0] map_len   [ENTRIES];
    logic [MODE_W-1:0]  map_perm  [ENTRIES];
    logic [COMP_W-1:0]  map_owner [ENTRIES];

    answer_t  answers_due [$];
    dir_row_t dir_rows [DIRECTED_ITEMS];
    int       errors  = 0;
    int       idle_cy = 0;
    bit       tx_calm = 1'b0;
    bit       rx_calm = 1'b0;

    mmio_range_match_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_address       (s_address),
        .s_region_size   (s_region_size),
        .s_access_size   (s_access_size),
        .s_access_mode   (s_access_mode),
        .s_component_id  (s_component_id),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_hit_component (m_hit_component),
        .m_offset        (m_offset)
    );

    always #2 aclk = ~aclk;

    // Range table model: decodes one item and updates the table
    function automatic answer_t decode_access(access_t it);
        answer_t ans;
        int i, free_idx, best, need;
        bit clash;
        logic [ADDR_W-1:0] b, l, n, sz;
        ans = '0;
        ans.status = STAT_NORANGE;
        free_idx = -1;
        best = -1;
        clash = 1'b0;
        n = 64'(it.rsize);
        sz = 64'(it.asize);
        if (it.op == OP_REGISTER) begin
            if (n == '0) begin
                ans.status = STAT_ZERO;
            end else begin
                for (i = 0; i < ENTRIES; i++) begin
                    if (map_used[i]) begin
                        b = map_base[i];
                        l = 64'(map_len[i]);
                        // spans meet, measured from the lower base
                        if (it.addr >= b) begin
                            if (it.addr - b < l) clash = 1'b1;
                        end else if (b - it.addr < n) begin
                            clash = 1'b1;
                        end
                    end else if (free_idx < 0) begin
                        free_idx = i;
                    end
                end
                if (clash) begin
                    ans.status = STAT_OVERLAP;
                end else if (free_idx < 0) begin
                    ans.status = STAT_FULL;
                end else begin
                    ans.status = STAT_OK;
                    map_used[free_idx]  = 1'b1;
                    map_base[free_idx]  = it.addr;
                    map_len[free_idx]   = it.rsize;
                    map_perm[free_idx]  = it.mode;
                    map_owner[free_idx] = it.comp;
                end
            end
        end else if (it.op == OP_READ || it.op == OP_WRITE) begin
            // whole access inside a range; the greatest base wins a tie
            for (i = 0; i < ENTRIES; i++) begin
                if (map_used[i]) begin
                    b = map_base[i];
                    l = 64'(map_len[i]);
                    if (!(it.addr < b || l < sz || it.addr - b > l - sz)) begin
                        if (best < 0 || b > map_base[best]) best = i;
                    end
                end
            end
            if (best >= 0) begin
                need = (it.op == OP_READ) ? MODE_READ_BIT : MODE_WRITE_BIT;
                if (!map_perm[best][need]) begin
                    ans.status = STAT_MODE;
                end else begin
                    ans.status = STAT_OK;
                    ans.hit    = map_owner[best];
                    ans.off    = OFF_W'(it.addr - map_base[best]);
                end
            end
        end
        return ans;
    endfunction

    // Random item: mostly registrations near stored ranges and aimed lookups
    function automatic access_t make_random_item();
        access_t it;
        int live [$];
        int k, pick, kind;
        logic [ADDR_W-1:0] ebase, off;
        logic [RSIZE_W-1:0] elen;
        it.op    = OP_READ;
        it.addr  = {$urandom, $urandom};
        it.rsize = $urandom;
        it.asize = ASIZE_W'($urandom_range(0, 127));
        it.mode  = MODE_W'($urandom_range(0, 3));
        it.comp  = COMP_W'($urandom_range(0, 255));
        for (k = 0; k < ENTRIES; k++) begin
            if (map_used[k]) live.push_back(k);
        end
        if (live.size() > 0) begin
            pick  = live[$urandom_range(0, live.size() - 1)];
            ebase = map_base[pick];
            elen  = map_len[pick];
        end else begin
            ebase = {$urandom, $urandom};
            elen  = $urandom_range(1, 256);
        end
        kind = $urandom_range(0, 99);
        if (kind < 22) begin
            it.op = OP_REGISTER;
            case ($urandom_range(0, 4))
                0: it.rsize = $urandom_range(1, 16);
                1: it.rsize = $urandom_range(1, 4096);
                2: it.rsize = $urandom;
                3: it.rsize = '1;
                default: it.rsize = $urandom_range(0, 1) ? '0 : $urandom_range(1, 64);
            endcase
            case ($urandom_range(0, 4))
                0: ;
                // just past or just into the end of a stored range
                1: it.addr = ebase + 64'(elen) + 64'($urandom_range(0, 6)) - 64'd3;
                // ending just before or just into a stored range
                2: it.addr = ebase - 64'(it.rsize) + 64'($urandom_range(0, 6)) - 64'd3;
                3: it.addr = '1 - 64'($urandom_range(0, 8192));
                default: it.addr = 64'($urandom_range(0, 65535));
            endcase
        end else if (kind < 92) begin
            it.op = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
            case ($urandom_range(0, 5))
                0: it.asize = '0;
                1: it.asize = ASIZE_W'($urandom_range(65, 127));
                default: it.asize = ASIZE_W'($urandom_range(1, 64));
            endcase
            case ($urandom_range(0, 4))
                0: off = '0;
                1: off = 64'(elen) - 64'(it.asize) + 64'($urandom_range(0, 4)) - 64'd2;
                2: off = 64'(elen);
                3: off = '0 - 64'($urandom_range(1, 3));
                default: off = 64'($urandom_range(0, elen));
            endcase
            it.addr = ebase + off;
        end else if (kind < 96) begin
            it.op = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
        end else begin
            it.op = OP_UNUSED;
        end
        return it;
    endfunction

    // Offer one item on the input channel and record its expected result
    task automatic offer_item(access_t it, logic typed, answer_t typed_ans);
        int gap;
        answer_t pred;
        gap = tx_calm ? 0 : $urandom_range(0, 9);
        if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_opcode       <= it.op;
        s_address      <= it.addr;
        s_region_size  <= it.rsize;
        s_access_size  <= it.asize;
        s_access_mode  <= it.mode;
        s_component_id <= it.comp;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pred = decode_access(it);
        answers_due.push_back(typed ? typed_ans : pred);
    endtask

    // Stimulus
    initial begin
        dir_rows = '{
            '{'{OP_READ,     64'h0,                  32'h0,   7'd1,  2'd0, 8'h00}, 1'b1,
              '{STAT_NORANGE, 8'h00, 32'h0}},
            '{'{OP_WRITE,    64'hFFFF_FFFF_FFFF_FFFF, 32'h0,   7'd64, 2'd0, 8'h00}, 1'b1,
              '{STAT_NORANGE, 8'h00, 32'h0}},
            '{'{OP_REGISTER, 64'h1000,               32'h0,   7'd0,  2'd3, 8'h11}, 1'b1,
              '{STAT_ZERO, 8'h00, 32'h0}},
            '{'{OP_UNUSED,   64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 7'h7F, 2'd3, 8'hFF}, 1'b1,
              '{STAT_NORANGE, 8'h00, 32'h0}},
            '{'{OP_REGISTER, 64'h1000,               32'h100, 7'd0,  2'd3, 8'h11}, 1'b1,
              '{STAT_OK, 8'h00, 32'h0}},
            '{'{OP_REGISTER, 64'h10FF,               32'h1,   7'd0,  2'd3, 8'h33}, 1'b1,
              '{STAT_OVERLAP, 8'h00, 32'h0}},
            // adjacent range with no permission at all
            '{'{OP_REGISTER, 64'h1100,               32'h100, 7'd0,  2'd0, 8'h22}, 1'b1,
              '{STAT_OK, 8'h00, 32'h0}},
            '{'{OP_READ,     64'h1000,               32'h0,   7'd4,  2'd0, 8'h00}, 1'b1,
              '{STAT_OK, 8'h11, 32'h0}},
            '{'{OP_WRITE,    64'h10FC,               32'h0,   7'd4,  2'd0, 8'h00}, 1'b1,
              '{STAT_OK, 8'h11, 32'hFC}},
            // access straddles two ranges
            '{'{OP_READ,     64'h10FD,               32'h0,   7'd4,  2'd0, 8'h00}, 1'b1,
              '{STAT_NORANGE, 8'h00, 32'h0}},
            // zero size at the seam: the higher base wins
            '{'{OP_READ,     64'h1100,               32'h0,   7'd0,  2'd0, 8'h00}, 1'b1,
              '{STAT_MODE, 8'h00, 32'h0}},
            '{'{OP_WRITE,    64'h1180,               32'h0,   7'd8,  2'd0, 8'h00}, 1'b1,
              '{STAT_MODE, 8'h00, 32'h0}},
            // range running past the top of the address space
            '{'{OP_REGISTER, 64'hFFFF_FFFF_FFFF_FF00, 32'hFFFF_FFFF, 7'd0, 2'd1, 8'hFF}, 1'b1,
              '{STAT_OK, 8'h00, 32'h0}},
            '{'{OP_READ,     64'hFFFF_FFFF_FFFF_FFC0, 32'h0,   7'd64, 2'd0, 8'h00}, 1'b1,
              '{STAT_OK, 8'hFF, 32'hC0}},
            '{'{OP_WRITE,    64'hFFFF_FFFF_FFFF_FFC0, 32'h0,   7'd64, 2'd0, 8'h00}, 1'b1,
              '{STAT_MODE, 8'h00, 32'h0}},
            '{'{OP_READ,     64'hFFFF_FFFF_FFFF_FFFF, 32'h0,   7'h7F, 2'd0, 8'h00}, 1'b0,
              '{STAT_OK, 8'h00, 32'h0}},
            '{'{OP_REGISTER, 64'hFFFF_FFFF_FFFF_FFFF, 32'h1,   7'd0,  2'd3, 8'h44}, 1'b1,
              '{STAT_OVERLAP, 8'h00, 32'h0}},
            '{'{OP_REGISTER, 64'h0,                  32'h10,  7'd0,  2'd2, 8'h00}, 1'b0,
              '{STAT_OK, 8'h00, 32'h0}},
            '{'{OP_WRITE,    64'h0,                  32'h0,   7'd16, 2'd0, 8'h00}, 1'b0,
              '{STAT_OK, 8'h00, 32'h0}},
            '{'{OP_WRITE,    64'h0,                  32'h0,   7'd17, 2'd0, 8'h00}, 1'b0,
              '{STAT_OK, 8'h00, 32'h0}},
            '{'{OP_READ,     64'h0,                  32'h0,   7'd4,  2'd0, 8'h00}, 1'b0,
              '{STAT_OK, 8'h00, 32'h0}},
            '{'{OP_READ,     64'h1000,               32'h0,   7'd0,  2'd0, 8'h00}, 1'b0,
              '{STAT_OK, 8'h00, 32'h0}},
            '{'{OP_WRITE,    64'h10FF,               32'h0,   7'd1,  2'd0, 8'h00}, 1'b0,
              '{STAT_OK, 8'h00, 32'h0}}
        };
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (dir_rows[r]) begin
            offer_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].ans);
        end
        repeat (RANDOM_ITEMS) begin
            offer_item(make_random_item(), 1'b0, '0);
        end
        s_valid <= 1'b0;
        // drain, then give the block time to show any stray result
        while (answers_due.size() > 0) @(posedge aclk);
        repeat (ENTRIES + 8) @(posedge aclk);
        if (errors == 0 && answers_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Result side: random stalls, then check each item against the oldest one due
    initial begin : result_side
        int stall;
        answer_t want;
        forever begin
            stall = rx_calm ? 0 : $urandom_range(0, 9);
            if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            if (answers_due.size() == 0) begin
                $error("result with nothing due: status %0d", m_status);
                errors++;
            end else begin
                want = answers_due.pop_front();
                if (m_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_status);
                    errors++;
                end
                if (m_hit_component !== want.hit) begin
                    $error("hit_component: expected 0x%0h, actual 0x%0h",
                           want.hit, m_hit_component);
                    errors++;
                end
                if (m_offset !== want.off) begin
                    $error("offset: expected 0x%0h, actual 0x%0h", want.off, m_offset);
                    errors++;
                end
            end
        end
    end

    // Watchdog: too long with no item moving on either channel
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cy <= 0;
            end else begin
                idle_cy <= idle_cy + 1;
            end
            if (idle_cy >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/mrmu_pkg.sv
sv/mrmu_ram.sv
sv/mrmu_cmp.sv
sv/mmio_range_match_unit.sv
sv/mrmu_checker.sv
tb/mmio_range_match_unit_tb.sv
